// ===== rtl/core/rdq_pkg.sv =====
package rdq_pkg;

    localparam int DEPTH  = 32;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_REAR   = 3'd3;
    localparam logic [2:0] OP_DUMP       = 3'd4;
    localparam logic [2:0] OP_SEARCH     = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [23:0] score;
        logic [63:0]        name;
    } t_rec;

    typedef struct packed {
        logic [1:0] status;
        t_rec       rec;
        logic       last;
    } t_res;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] raddr;
        t_rec              wdata;
    } t_mem_req;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(DEPTH - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_W'(DEPTH - 1) : s - SLOT_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                   input logic [CNT_W-1:0]  c);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(s) + SUM_W'(c);
        return (sum >= SUM_W'(DEPTH)) ? SLOT_W'(sum - SUM_W'(DEPTH)) : SLOT_W'(sum);
    endfunction

endpackage

// ===== rtl/core/rdq_if.sv =====
interface rdq_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [31:0] record_key;
    logic signed [23:0] score_hundredths;
    logic [63:0]        name_chars;

    modport source (output valid, output opcode, output record_key,
                    output score_hundredths, output name_chars, input ready);
    modport sink   (input valid, input opcode, input record_key,
                    input score_hundredths, input name_chars, output ready);
endinterface

interface rdq_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] out_key;
    logic signed [23:0] out_score;
    logic [63:0]        out_name;
    logic               last_result;

    modport source (output valid, output status, output out_key, output out_score,
                    output out_name, output last_result, input ready);
    modport sink   (input valid, input status, input out_key, input out_score,
                    input out_name, input last_result, output ready);
endinterface

// ===== rtl/core/rdq_mem.sv =====
module rdq_mem (
    input  logic              i_clk,
    input  rdq_pkg::t_mem_req i_req,
    output rdq_pkg::t_rec     o_rd_rec
);

    rdq_pkg::t_rec r_mem [rdq_pkg::DEPTH];
    rdq_pkg::t_rec r_rd_rec;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_rec <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_rec = r_rd_rec;

endmodule

// ===== rtl/core/rdq_seq.sv =====
module rdq_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rdq_in_if.sink            i_item,
    input  logic              i_out_free,
    output logic              o_emit,
    output rdq_pkg::t_res     o_res,
    output rdq_pkg::t_mem_req o_mem_req,
    input  rdq_pkg::t_rec     i_rd_rec
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [2:0]                  r_op, n_op;
    logic signed [31:0]          r_key, n_key;
    logic [rdq_pkg::SLOT_W-1:0]  r_front, n_front;
    logic [rdq_pkg::CNT_W-1:0]   r_count, n_count;
    logic [rdq_pkg::SLOT_W-1:0]  r_slot, n_slot;
    logic [rdq_pkg::CNT_W-1:0]   r_left, n_left;
    logic [1:0]                  r_status, n_status;

    logic accept;
    logic full;
    logic empty;
    logic hit;
    logic last_visit;

    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign full         = (r_count == rdq_pkg::CNT_W'(rdq_pkg::DEPTH));
    assign empty        = (r_count == '0);
    assign hit          = (i_rd_rec.key == r_key);
    assign last_visit   = (r_left == rdq_pkg::CNT_W'(1));

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_front  = r_front;
        n_count  = r_count;
        n_slot   = r_slot;
        n_left   = r_left;
        n_status = r_status;
        o_emit   = 1'b0;
        o_res    = '0;

        o_mem_req             = '0;
        o_mem_req.raddr       = r_slot;
        o_mem_req.waddr       = rdq_pkg::slot_add(r_front, r_count);
        o_mem_req.wdata.key   = i_item.record_key;
        o_mem_req.wdata.score = i_item.score_hundredths;
        o_mem_req.wdata.name  = i_item.name_chars;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op  = i_item.opcode;
                    n_key = i_item.record_key;
                    unique case (i_item.opcode) inside
                        rdq_pkg::OP_PUSH_FRONT, rdq_pkg::OP_PUSH_REAR: begin
                            n_state = S_RESP;
                            if (full) begin
                                n_status = rdq_pkg::ST_FULL;
                            end else begin
                                n_status     = rdq_pkg::ST_OK;
                                o_mem_req.we = 1'b1;
                                n_count      = r_count + rdq_pkg::CNT_W'(1);
                                if (i_item.opcode == rdq_pkg::OP_PUSH_FRONT) begin
                                    n_front         = rdq_pkg::slot_dec(r_front);
                                    o_mem_req.waddr = rdq_pkg::slot_dec(r_front);
                                end
                            end
                        end
                        rdq_pkg::OP_POP_FRONT, rdq_pkg::OP_POP_REAR,
                        rdq_pkg::OP_DUMP, rdq_pkg::OP_SEARCH: begin
                            if (empty) begin
                                n_state  = S_RESP;
                                n_status = rdq_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_READ;
                                n_left  = r_count;
                                n_slot  = r_front;
                                if (i_item.opcode == rdq_pkg::OP_POP_FRONT) begin
                                    n_front = rdq_pkg::slot_inc(r_front);
                                    n_count = r_count - rdq_pkg::CNT_W'(1);
                                end else if (i_item.opcode == rdq_pkg::OP_POP_REAR) begin
                                    n_slot  = rdq_pkg::slot_add(r_front,
                                                  r_count - rdq_pkg::CNT_W'(1));
                                    n_count = r_count - rdq_pkg::CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                o_mem_req.re = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                if (r_op == rdq_pkg::OP_SEARCH && !hit) begin
                    if (last_visit) begin
                        n_state  = S_RESP;
                        n_status = rdq_pkg::ST_NOT_FOUND;
                    end else begin
                        n_left  = r_left - rdq_pkg::CNT_W'(1);
                        n_slot  = rdq_pkg::slot_inc(r_slot);
                        n_state = S_READ;
                    end
                end else if (i_out_free) begin
                    o_emit       = 1'b1;
                    o_res.status = rdq_pkg::ST_OK;
                    o_res.rec    = i_rd_rec;
                    o_res.last   = (r_op != rdq_pkg::OP_DUMP) || last_visit;
                    if (o_res.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_left  = r_left - rdq_pkg::CNT_W'(1);
                        n_slot  = rdq_pkg::slot_inc(r_slot);
                        n_state = S_READ;
                    end
                end
            end
            S_RESP: begin
                if (i_out_free) begin
                    o_emit       = 1'b1;
                    o_res.status = r_status;
                    o_res.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_slot   <= n_slot;
        r_left   <= n_left;
        r_status <= n_status;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rdq_pkg::CNT_W'(rdq_pkg::DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !full && (i_item.opcode == rdq_pkg::OP_PUSH_FRONT ||
                            i_item.opcode == rdq_pkg::OP_PUSH_REAR)
        |=> r_count == $past(r_count) + rdq_pkg::CNT_W'(1))
        else $error("An accepted push did not add one entry.");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !empty && (i_item.opcode == rdq_pkg::OP_POP_FRONT ||
                             i_item.opcode == rdq_pkg::OP_POP_REAR)
        |=> r_count == $past(r_count) - rdq_pkg::CNT_W'(1))
        else $error("An accepted pop did not remove one entry.");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> i_out_free)
        else $error("A result was produced while the output register was occupied.");

    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_CHECK) |-> r_left != '0)
        else $error("A record walk runs with no entries left to visit.");
`endif

endmodule

// ===== rtl/core/record_deque_with_key_search_top.sv =====
// Bounded double-ended queue of up to rdq_pkg::DEPTH records (key, score, 8-character
// name) held in a single-write, single-read memory with a registered read port. A push
// or an operation on an empty queue passes through a response state that hands its one
// result to the output register; a pop first reads its record from the memory, then hands
// it on. Dump and search walk the records from the front through the one memory read port,
// each record visited taking a read, then a compare or emit, and an emit waits while the
// output register is occupied. A new item is accepted once the previous one has handed its
// last result to the output register, which then waits for the sink on its own.
module record_deque_with_key_search_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rdq_in_if.sink    i_item,
    rdq_out_if.source o_result
);

    rdq_pkg::t_mem_req mem_req;
    rdq_pkg::t_rec     rd_rec;
    rdq_pkg::t_res     res;
    logic              emit;
    logic              out_free;

    logic              r_out_valid;
    rdq_pkg::t_res     r_out;

    assign out_free = !r_out_valid || o_result.ready;

    rdq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_out_free (out_free),
        .o_emit     (emit),
        .o_res      (res),
        .o_mem_req  (mem_req),
        .i_rd_rec   (rd_rec)
    );

    rdq_mem u_mem (
        .i_clk    (i_clk),
        .i_req    (mem_req),
        .o_rd_rec (rd_rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_out.status;
    assign o_result.out_key     = r_out.rec.key;
    assign o_result.out_score   = r_out.rec.score;
    assign o_result.out_name    = r_out.rec.name;
    assign o_result.last_result = r_out.last;

endmodule

// ===== tb/testbench.sv =====
module testbench;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam int N_RANDOM      = 220;
    localparam int TAIL_QUIET    = 30;
    localparam int SETTLE_CYCLES = 2 * rdq_pkg::DEPTH + 16;
    localparam int HOLD_AT       = 70;
    localparam int HOLD_LEN      = 400;
    localparam int MID_DRAIN_AT  = 130;

    typedef struct {
        logic [2:0]         opcode;
        logic signed [31:0] key;
        logic signed [23:0] score;
        logic [63:0]        name;
        bit                 drain_first;
    } t_stim;

    logic i_clk;
    logic i_rst_n;

    rdq_in_if  in_if ();
    rdq_out_if out_if ();

    record_deque_with_key_search_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_if),
        .o_result (out_if)
    );

    t_stim         pending_items[$];
    rdq_pkg::t_res expected_results[$];
    t_stim         cur_item;

    rdq_pkg::t_rec deque_mem [rdq_pkg::DEPTH];
    int            front_idx;
    int            rec_count;

    int gen_count;
    int n_generated;
    bit drain_next;

    int n_accepted;
    int n_checked;
    int n_errors;
    int n_pushes;
    int n_full;
    int n_empty;
    int n_dumped;
    int n_hits;
    int n_misses;
    int n_ignored;
    int total_items;
    int in_gap;
    int out_gap;
    int hold_left;
    bit hold_started;
    bit quiet_tail;

    always #5 i_clk = ~i_clk;

    function automatic rdq_pkg::t_res make_res(input logic [1:0] st, input rdq_pkg::t_rec r,
                                               input logic last);
        rdq_pkg::t_res x;
        x.status = st;
        x.rec    = r;
        x.last   = last;
        return x;
    endfunction

    // Updates the deque image and queues every result that the item causes.
    task automatic predict_item(input t_stim s);
        rdq_pkg::t_rec zero_rec;
        rdq_pkg::t_rec new_rec;
        int            slot;
        bit            hit;
        zero_rec      = '0;
        new_rec.key   = s.key;
        new_rec.score = s.score;
        new_rec.name  = s.name;
        hit           = 1'b0;
        case (s.opcode)
            rdq_pkg::OP_PUSH_FRONT, rdq_pkg::OP_PUSH_REAR: begin
                if (rec_count >= rdq_pkg::DEPTH) begin
                    expected_results.push_back(make_res(rdq_pkg::ST_FULL, zero_rec, 1'b1));
                    n_full++;
                end else begin
                    if (s.opcode == rdq_pkg::OP_PUSH_FRONT) begin
                        front_idx = (front_idx + rdq_pkg::DEPTH - 1) % rdq_pkg::DEPTH;
                        slot = front_idx;
                    end else begin
                        slot = (front_idx + rec_count) % rdq_pkg::DEPTH;
                    end
                    deque_mem[slot] = new_rec;
                    rec_count++;
                    expected_results.push_back(make_res(rdq_pkg::ST_OK, zero_rec, 1'b1));
                    n_pushes++;
                end
            end
            rdq_pkg::OP_POP_FRONT, rdq_pkg::OP_POP_REAR, rdq_pkg::OP_DUMP,
            rdq_pkg::OP_SEARCH: begin
                if (rec_count == 0) begin
                    expected_results.push_back(make_res(rdq_pkg::ST_EMPTY, zero_rec, 1'b1));
                    n_empty++;
                end else if (s.opcode == rdq_pkg::OP_POP_FRONT) begin
                    expected_results.push_back(make_res(rdq_pkg::ST_OK, deque_mem[front_idx],
                                                        1'b1));
                    front_idx = (front_idx + 1) % rdq_pkg::DEPTH;
                    rec_count--;
                end else if (s.opcode == rdq_pkg::OP_POP_REAR) begin
                    slot = (front_idx + rec_count - 1) % rdq_pkg::DEPTH;
                    expected_results.push_back(make_res(rdq_pkg::ST_OK, deque_mem[slot],
                                                        1'b1));
                    rec_count--;
                end else if (s.opcode == rdq_pkg::OP_DUMP) begin
                    for (int i = 0; i < rec_count; i++) begin
                        slot = (front_idx + i) % rdq_pkg::DEPTH;
                        expected_results.push_back(make_res(rdq_pkg::ST_OK, deque_mem[slot],
                                                            i == rec_count - 1));
                        n_dumped++;
                    end
                end else begin
                    for (int i = 0; i < rec_count; i++) begin
                        slot = (front_idx + i) % rdq_pkg::DEPTH;
                        if (!hit && deque_mem[slot].key == s.key) begin
                            hit = 1'b1;
                            expected_results.push_back(make_res(rdq_pkg::ST_OK,
                                                                deque_mem[slot], 1'b1));
                        end
                    end
                    if (hit) begin
                        n_hits++;
                    end else begin
                        expected_results.push_back(make_res(rdq_pkg::ST_NOT_FOUND, zero_rec,
                                                            1'b1));
                        n_misses++;
                    end
                end
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    function automatic bit field_ok(input string what, input logic [63:0] want,
                                    input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic check_result(input rdq_pkg::t_res got);
        rdq_pkg::t_res want;
        bit            ok;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual status %0d key %h last %b",
                     $time, got.status, got.rec.key, got.last);
            n_errors++;
        end else begin
            want = expected_results.pop_front();
            n_checked++;
            ok = field_ok("status", {62'b0, want.status}, {62'b0, got.status});
            ok &= field_ok("out_key", {32'b0, want.rec.key}, {32'b0, got.rec.key});
            ok &= field_ok("out_score", {40'b0, want.rec.score}, {40'b0, got.rec.score});
            ok &= field_ok("out_name", want.rec.name, got.rec.name);
            ok &= field_ok("last_result", {63'b0, want.last}, {63'b0, got.last});
            if (!ok) begin
                n_errors++;
            end
        end
    endtask

    function automatic logic signed [31:0] pick_key();
        logic signed [31:0] pool [8];
        pool = '{32'sd0, 32'sd1, 32'sd2, 32'sd5, -32'sd1, 32'h7fff_ffff, 32'h8000_0000,
                 32'sd1000};
        if ($urandom_range(0, 1) == 0) begin
            return pool[$urandom_range(0, 7)];
        end
        return $urandom;
    endfunction

    function automatic logic [63:0] pick_name();
        logic [63:0] n;
        int          len;
        n = '0;
        if ($urandom_range(0, 1) == 0) begin
            n = {$urandom, $urandom};
        end else begin
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++) begin
                n[8*i +: 8] = 8'($urandom_range(32, 126));
            end
        end
        return n;
    endfunction

    task automatic add_item(input logic [2:0] op, input logic signed [31:0] key,
                            input logic signed [23:0] score, input logic [63:0] name);
        t_stim s;
        s.opcode      = op;
        s.key         = key;
        s.score       = score;
        s.name        = name;
        s.drain_first = drain_next;
        drain_next    = 1'b0;
        pending_items.push_back(s);
        if (op <= rdq_pkg::OP_SEARCH) begin
            n_generated++;
        end
        if ((op == rdq_pkg::OP_PUSH_FRONT || op == rdq_pkg::OP_PUSH_REAR) &&
            gen_count < rdq_pkg::DEPTH) begin
            gen_count++;
        end else if ((op == rdq_pkg::OP_POP_FRONT || op == rdq_pkg::OP_POP_REAR) &&
                     gen_count > 0) begin
            gen_count--;
        end
    endtask

    task automatic add_op(input logic [2:0] op);
        add_item(op, pick_key(), 24'($urandom), pick_name());
    endtask

    task automatic build_stimulus();
        int          seg;
        int          len;
        int          r;
        logic [2:0]  op;
        bit          mid_drain_done;
        mid_drain_done = 1'b0;

        // Operations on an empty deque.
        add_item(rdq_pkg::OP_POP_FRONT, 32'sd0, 24'sd0, 64'd0);
        add_item(rdq_pkg::OP_POP_REAR, 32'sd0, 24'sd0, 64'd0);
        add_item(rdq_pkg::OP_DUMP, 32'sd0, 24'sd0, 64'd0);
        add_item(rdq_pkg::OP_SEARCH, 32'sd0, 24'sd0, 64'd0);
        // Field extremes, with a duplicated key to check that a search takes the first match.
        add_item(rdq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff, 24'h7f_ffff, '1);
        add_item(rdq_pkg::OP_PUSH_REAR, 32'h8000_0000, 24'h80_0000, 64'd0);
        add_item(rdq_pkg::OP_PUSH_FRONT, -32'sd1, -24'sd1, 64'h4847_4645_4443_4241);
        add_item(rdq_pkg::OP_PUSH_REAR, 32'h7fff_ffff, 24'sd0, 64'h41);
        add_item(rdq_pkg::OP_DUMP, 32'sd0, 24'sd0, 64'd0);
        add_item(rdq_pkg::OP_SEARCH, 32'h7fff_ffff, 24'sd0, 64'd0);
        add_item(rdq_pkg::OP_SEARCH, 32'sd12345, 24'sd0, 64'd0);
        add_item(OP_SPARE_A, '1, '1, '1);
        add_item(OP_SPARE_B, 32'sd0, 24'sd0, 64'd0);
        add_item(rdq_pkg::OP_POP_FRONT, 32'sd0, 24'sd0, 64'd0);
        add_item(rdq_pkg::OP_POP_REAR, 32'sd0, 24'sd0, 64'd0);
        add_item(rdq_pkg::OP_SEARCH, 32'h8000_0000, 24'sd0, 64'd0);
        add_item(rdq_pkg::OP_POP_REAR, 32'sd0, 24'sd0, 64'd0);
        add_item(rdq_pkg::OP_POP_FRONT, 32'sd0, 24'sd0, 64'd0);
        add_item(rdq_pkg::OP_POP_FRONT, 32'sd0, 24'sd0, 64'd0);
        add_item(rdq_pkg::OP_PUSH_REAR, 32'sd42, 24'sd1234, 64'h6f6c_6c65_68);
        add_item(rdq_pkg::OP_DUMP, 32'sd0, 24'sd0, 64'd0);
        add_item(rdq_pkg::OP_POP_REAR, 32'sd0, 24'sd0, 64'd0);

        drain_next = 1'b1;
        while (n_generated < N_RANDOM) begin
            if (!mid_drain_done && n_generated >= MID_DRAIN_AT) begin
                drain_next     = 1'b1;
                mid_drain_done = 1'b1;
            end
            seg = $urandom_range(0, 9);
            if (seg < 2) begin
                while (gen_count < rdq_pkg::DEPTH) begin
                    add_op($urandom_range(0, 1) ? rdq_pkg::OP_PUSH_FRONT
                                                : rdq_pkg::OP_PUSH_REAR);
                end
                len = $urandom_range(1, 2);
                for (int i = 0; i < len; i++) begin
                    add_op($urandom_range(0, 1) ? rdq_pkg::OP_PUSH_FRONT
                                                : rdq_pkg::OP_PUSH_REAR);
                end
                add_op(rdq_pkg::OP_DUMP);
                add_op(rdq_pkg::OP_SEARCH);
            end else if (seg < 4) begin
                while (gen_count > 0) begin
                    add_op($urandom_range(0, 1) ? rdq_pkg::OP_POP_FRONT
                                                : rdq_pkg::OP_POP_REAR);
                end
                case ($urandom_range(0, 3))
                    0: add_op(rdq_pkg::OP_POP_FRONT);
                    1: add_op(rdq_pkg::OP_POP_REAR);
                    2: add_op(rdq_pkg::OP_DUMP);
                    default: add_op(rdq_pkg::OP_SEARCH);
                endcase
            end else begin
                len = $urandom_range(5, 20);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 20) op = rdq_pkg::OP_PUSH_FRONT;
                    else if (r < 40) op = rdq_pkg::OP_PUSH_REAR;
                    else if (r < 52) op = rdq_pkg::OP_POP_FRONT;
                    else if (r < 64) op = rdq_pkg::OP_POP_REAR;
                    else if (r < 86) op = rdq_pkg::OP_SEARCH;
                    else if (r < 96) op = rdq_pkg::OP_DUMP;
                    else if (r < 98) op = OP_SPARE_A;
                    else op = OP_SPARE_B;
                    add_op(op);
                end
            end
        end
        total_items = pending_items.size();
    endtask

    always @(posedge i_clk) begin
        logic next_valid;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_gap = 0;
        end else begin
            next_valid = in_if.valid;
            if (in_if.valid && in_if.ready) begin
                predict_item(cur_item);
                n_accepted <= n_accepted + 1;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_items.size() != 0) begin
                    if (pending_items[0].drain_first && expected_results.size() != 0) begin
                        next_valid = 1'b0;
                    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                        in_gap = $urandom_range(0, 15);
                    end else begin
                        cur_item = pending_items.pop_front();
                        in_if.opcode           <= cur_item.opcode;
                        in_if.record_key       <= cur_item.key;
                        in_if.score_hundredths <= cur_item.score;
                        in_if.name_chars       <= cur_item.name;
                        next_valid = 1'b1;
                    end
                end
            end
            in_if.valid <= next_valid;
            quiet_tail  <= (pending_items.size() < TAIL_QUIET);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left    <= 0;
            hold_started <= 1'b0;
        end else if (!hold_started && n_accepted >= HOLD_AT) begin
            hold_started <= 1'b1;
            hold_left    <= HOLD_LEN;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        rdq_pkg::t_res got;
        logic          next_ready;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got.status    = out_if.status;
                got.rec.key   = out_if.out_key;
                got.rec.score = out_if.out_score;
                got.rec.name  = out_if.out_name;
                got.last      = out_if.last_result;
                check_result(got);
            end
            if (hold_left > 0) begin
                next_ready = 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                next_ready = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                out_gap = $urandom_range(0, 15);
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            out_if.ready <= next_ready;
        end
    end

    initial begin
        i_clk                  = 1'b0;
        i_rst_n                = 1'b0;
        in_if.valid            = 1'b0;
        in_if.opcode           = rdq_pkg::OP_PUSH_FRONT;
        in_if.record_key       = '0;
        in_if.score_hundredths = '0;
        in_if.name_chars       = '0;
        out_if.ready           = 1'b0;
        front_idx    = 0;
        rec_count    = 0;
        gen_count    = 0;
        n_generated  = 0;
        drain_next   = 1'b0;
        n_accepted   = 0;
        n_checked    = 0;
        n_errors     = 0;
        n_pushes     = 0;
        n_full       = 0;
        n_empty      = 0;
        n_dumped     = 0;
        n_hits       = 0;
        n_misses     = 0;
        n_ignored    = 0;
        quiet_tail   = 1'b0;
        build_stimulus();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_accepted < total_items || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d items: %0d stored, %0d refused as full, %0d on an empty deque,",
                 total_items, n_pushes, n_full, n_empty);
        $display("%0d ignored; checked %0d results, among them %0d dumped records, %0d hits, %0d misses.",
                 n_ignored, n_checked, n_dumped, n_hits, n_misses);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("[record_deque_with_key_search_top] OK");
        end else begin
            $display("[record_deque_with_key_search_top] ERROR");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("Timed out with %0d of %0d items sent.", n_accepted, total_items);
        $display("[record_deque_with_key_search_top] ERROR");
        $finish;
    end

endmodule
